// ===== rtl/core/gidt_pkg.sv =====
package gidt_pkg;

    localparam int SLOTS    = 64;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int SLOT_W   = 7;
    localparam int GEN_W    = 32;
    localparam int KEY_W    = 64;
    localparam int KIND_W   = 3;
    localparam int LIVE_W   = 7;
    localparam int STATUS_W = 3;
    localparam logic [KIND_W-1:0] KIND_MAX = 3'd5;

    typedef enum logic [1:0] {
        CMD_INTERN  = 2'd0,
        CMD_RESOLVE = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_CLEAR   = 2'd3
    } gidt_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_FULL     = 3'd2,
        ST_STALE    = 3'd3,
        ST_MISMATCH = 3'd4
    } gidt_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_SCAN_END,
        S_HCHECK
    } gidt_state_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key_low;
        logic [KEY_W-1:0]  key_high;
        logic [SLOT_W-1:0] handle_slot;
        logic [GEN_W-1:0]  handle_generation;
    } gidt_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   out_slot;
        logic [GEN_W-1:0]    out_generation;
        logic [KEY_W-1:0]    out_key_low;
        logic [KEY_W-1:0]    out_key_high;
        logic [LIVE_W-1:0]   live_count;
    } gidt_rsp_t;

    // one table entry as stored in the key RAM
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key_high;
        logic [KEY_W-1:0]  key_low;
    } gidt_entry_t;

    localparam int ENTRY_W = $bits(gidt_entry_t);

    // controller -> datapath
    typedef struct packed {
        logic         load;
        logic         sweep_init;
        logic         sweep_step;
        logic         hread;
        logic         fill;
        logic         free_slot;
        logic         finish;
        gidt_status_t status;
    } gidt_ctl_t;

    // datapath -> controller
    typedef struct packed {
        gidt_cmd_t command;
        logic      arg_ok;
        logic      sweep_done;
        logic      hit;
        logic      free_found;
        logic      stale;
        logic      mismatch;
    } gidt_sts_t;

    // generation bump, skipping zero on wrap
    function automatic logic [GEN_W-1:0] gen_bump(input logic [GEN_W-1:0] g);
        logic [GEN_W-1:0] n;
        n = g + GEN_W'(1);
        return (n == '0) ? GEN_W'(1) : n;
    endfunction

endpackage

// ===== rtl/core/gidt_ram.sv =====
module gidt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/gidt_datapath.sv =====
module gidt_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  gidt_pkg::gidt_req_t request,
    input  gidt_pkg::gidt_ctl_t ctl,
    output gidt_pkg::gidt_sts_t sts,
    output logic              done,
    output gidt_pkg::gidt_rsp_t result
);
    import gidt_pkg::*;

    gidt_req_t             item_reg;
    gidt_cmd_t             cmd;
    logic [SLOTS-1:0]      used_reg, used_next;
    logic [SLOTS-1:0]      gvld_reg, gvld_next;
    logic [LIVE_W-1:0]     total_reg, total_next;
    logic [IDX_W-1:0]      ptr_reg;
    logic                  ptr_run_reg;
    logic                  cmp_vld_reg;
    logic [IDX_W-1:0]      q_idx_reg;
    logic                  hit_reg, free_found_reg;
    logic [IDX_W-1:0]      hit_idx_reg, free_idx_reg;
    logic [GEN_W-1:0]      hit_gen_reg, free_gen_reg;
    logic                  done_reg;
    gidt_rsp_t             result_reg, result_next;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [IDX_W-1:0]      hidx;
    logic [ENTRY_W-1:0]    key_q;
    gidt_entry_t           entry_q;
    logic [GEN_W-1:0]      gen_q, gen_rd, fill_gen;
    logic                  key_we;
    gidt_entry_t           key_wentry;
    logic                  gen_we;
    logic [IDX_W-1:0]      gen_waddr;
    logic [GEN_W-1:0]      gen_wdata;
    logic                  match_now, free_now, sweep_wr;

    assign cmd     = gidt_cmd_t'(item_reg.command);
    assign hidx    = IDX_W'(item_reg.handle_slot - SLOT_W'(1));
    assign rd_en   = ctl.hread | (ctl.sweep_step & ptr_run_reg);
    assign rd_addr = ctl.hread ? hidx : ptr_reg;
    assign entry_q = gidt_entry_t'(key_q);
    // a generation never written reads as zero
    assign gen_rd  = gvld_reg[q_idx_reg] ? gen_q : '0;
    assign fill_gen = (free_gen_reg == '0) ? GEN_W'(1) : free_gen_reg;

    assign match_now = cmp_vld_reg && (cmd == CMD_INTERN) && used_reg[q_idx_reg]
                       && (entry_q.kind == item_reg.kind)
                       && (entry_q.key_low == item_reg.key_low)
                       && (entry_q.key_high == item_reg.key_high);
    assign free_now  = cmp_vld_reg && (cmd == CMD_INTERN) && !used_reg[q_idx_reg]
                       && !free_found_reg;
    assign sweep_wr  = ctl.sweep_step && cmp_vld_reg && (cmd == CMD_CLEAR);

    always_comb
    begin
        sts.command    = cmd;
        sts.sweep_done = cmp_vld_reg && (match_now || (q_idx_reg == IDX_W'(SLOTS - 1)));
        sts.hit        = hit_reg;
        sts.free_found = free_found_reg;
        sts.stale      = !used_reg[q_idx_reg] || (gen_rd != item_reg.handle_generation);
        sts.mismatch   = entry_q.kind != item_reg.kind;
        unique case (cmd)
            CMD_INTERN:
                sts.arg_ok = (item_reg.kind <= KIND_MAX)
                             && ((item_reg.key_low | item_reg.key_high) != '0);
            CMD_RESOLVE, CMD_RELEASE:
                sts.arg_ok = (item_reg.kind <= KIND_MAX)
                             && (item_reg.handle_slot != '0)
                             && (int'(item_reg.handle_slot) <= SLOTS)
                             && (item_reg.handle_generation != '0);
            CMD_CLEAR:
                sts.arg_ok = 1'b1;
        endcase
    end

    // RAM write ports and per-slot flags
    always_comb
    begin
        key_we     = ctl.fill;
        key_wentry = '{kind: item_reg.kind, key_high: item_reg.key_high,
                       key_low: item_reg.key_low};
        gen_we     = 1'b0;
        gen_waddr  = q_idx_reg;
        gen_wdata  = gen_bump(gen_rd);
        used_next  = used_reg;
        gvld_next  = gvld_reg;
        total_next = total_reg;
        priority if (ctl.fill)
        begin
            gen_we                  = 1'b1;
            gen_waddr               = free_idx_reg;
            gen_wdata               = fill_gen;
            used_next[free_idx_reg] = 1'b1;
            gvld_next[free_idx_reg] = 1'b1;
            total_next              = total_reg + LIVE_W'(1);
        end
        else if (ctl.free_slot || sweep_wr)
        begin
            gen_we               = 1'b1;
            used_next[q_idx_reg] = 1'b0;
            gvld_next[q_idx_reg] = 1'b1;
            if (ctl.free_slot)
            begin
                total_next = total_reg - LIVE_W'(1);
            end
        end
        if (ctl.finish && (cmd == CMD_CLEAR))
        begin
            total_next = '0;
        end
    end

    always_comb
    begin
        result_next            = '0;
        result_next.status     = ctl.status;
        result_next.live_count = total_next;
        if (ctl.status == ST_OK)
        begin
            unique case (cmd)
                CMD_INTERN:
                begin
                    if (hit_reg)
                    begin
                        result_next.out_slot       = SLOT_W'(hit_idx_reg) + SLOT_W'(1);
                        result_next.out_generation = hit_gen_reg;
                    end
                    else
                    begin
                        result_next.out_slot       = SLOT_W'(free_idx_reg) + SLOT_W'(1);
                        result_next.out_generation = fill_gen;
                    end
                end
                CMD_RESOLVE:
                begin
                    result_next.out_key_low  = entry_q.key_low;
                    result_next.out_key_high = entry_q.key_high;
                end
                CMD_RELEASE, CMD_CLEAR:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            gvld_reg       <= '0;
            total_reg      <= '0;
            ptr_reg        <= '0;
            ptr_run_reg    <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            gvld_reg  <= gvld_next;
            total_reg <= total_next;
            done_reg  <= ctl.finish;
            if (ctl.sweep_init)
            begin
                ptr_reg        <= '0;
                ptr_run_reg    <= 1'b1;
                cmp_vld_reg    <= 1'b0;
                hit_reg        <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (ctl.sweep_step)
            begin
                if (ptr_run_reg)
                begin
                    ptr_reg     <= ptr_reg + IDX_W'(1);
                    ptr_run_reg <= ptr_reg != IDX_W'(SLOTS - 1);
                end
                cmp_vld_reg <= ptr_run_reg;
                if (match_now)
                begin
                    hit_reg <= 1'b1;
                end
                if (free_now)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            else
            begin
                cmp_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= request;
        end
        if (rd_en)
        begin
            q_idx_reg <= rd_addr;
        end
        if (ctl.sweep_step && match_now)
        begin
            hit_idx_reg <= q_idx_reg;
            hit_gen_reg <= gen_rd;
        end
        if (ctl.sweep_step && free_now)
        begin
            free_idx_reg <= q_idx_reg;
            free_gen_reg <= gen_rd;
        end
        if (ctl.finish)
        begin
            result_reg <= result_next;
        end
    end

    gidt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (free_idx_reg),
        .wdata (key_wentry),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (key_q)
    );

    gidt_ram #(
        .WIDTH (GEN_W),
        .DEPTH (SLOTS)
    ) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (gen_q)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/core/gidt_ctrl.sv =====
module gidt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gidt_pkg::gidt_sts_t sts,
    output gidt_pkg::gidt_ctl_t ctl
);
    import gidt_pkg::*;

    gidt_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (!sts.arg_ok)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.command == CMD_RESOLVE || sts.command == CMD_RELEASE)
                begin
                    state_next = S_HCHECK;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.sweep_done)
                begin
                    state_next = (sts.command == CMD_CLEAR) ? S_IDLE : S_SCAN_END;
                end
            end
            S_SCAN_END, S_HCHECK:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl  = '0;
        ctl.status = ST_OK;
        busy = state_reg != S_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.load = start;
            end
            S_DISPATCH:
            begin
                if (!sts.arg_ok)
                begin
                    ctl.finish = 1'b1;
                    ctl.status = ST_INVALID;
                end
                else if (sts.command == CMD_RESOLVE || sts.command == CMD_RELEASE)
                begin
                    ctl.hread = 1'b1;
                end
                else
                begin
                    ctl.sweep_init = 1'b1;
                end
            end
            S_SCAN:
            begin
                ctl.sweep_step = 1'b1;
                if (sts.sweep_done && sts.command == CMD_CLEAR)
                begin
                    ctl.finish = 1'b1;
                end
            end
            S_SCAN_END:
            begin
                ctl.finish = 1'b1;
                priority if (sts.hit)
                begin
                    ctl.status = ST_OK;
                end
                else if (sts.free_found)
                begin
                    ctl.fill = 1'b1;
                end
                else
                begin
                    ctl.status = ST_FULL;
                end
            end
            S_HCHECK:
            begin
                ctl.finish = 1'b1;
                priority if (sts.stale)
                begin
                    ctl.status = ST_STALE;
                end
                else if (sts.mismatch)
                begin
                    ctl.status = ST_MISMATCH;
                end
                else
                begin
                    ctl.free_slot = sts.command == CMD_RELEASE;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== rtl/core/generational_identity_table.sv =====
// Slot map of 64 tagged 128-bit keys addressed by one-based, generation-checked
// handles. A command transfers when start is high and busy is low; the result
// is presented for exactly one cycle with done high, in the first cycle that busy
// is low again, and must be taken then since the block cannot be stalled. A new
// command may start in the cycle its predecessor's result is shown. Intern and
// clear walk the table one slot per cycle through the key and generation RAMs;
// intern stops early on a match. Generations reset to zero through per-slot
// valid bits, so no clearing pass is needed after reset.
module generational_identity_table (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  gidt_pkg::gidt_req_t request,
    output logic              done,
    output gidt_pkg::gidt_rsp_t result
);
    import gidt_pkg::*;

    gidt_ctl_t ctl;
    gidt_sts_t sts;

    gidt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    gidt_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule
